// ----- src/binary_trie_prefix_lookup_core_defines.svh -----
// ----------------------------------------------------------------------------
// Binary trie prefix lookup: assertion macros
// Shared assertion wrappers clocked on i_clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_PREFIX_LOOKUP_CORE_DEFINES_SVH
`define BINARY_TRIE_PREFIX_LOOKUP_CORE_DEFINES_SVH

// Checked only while reset is released.
`define BTRIE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every rising edge of i_clk, reset included.
`define BTRIE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- src/btrie_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary trie prefix lookup package
// Shared constants, opcodes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package btrie_pkg;

    localparam int NODE_COUNT_DEF   = 4096;
    localparam int ADDRESS_BITS_DEF = 32;

    localparam int ADDR_IN_W = 32;
    localparam int PLEN_W    = 6;
    localparam int PORT_W    = 16;

    localparam logic [PORT_W-1:0] MISS_PORT = 16'hFFFF;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new item and start at the root
        logic rd;      // read the current node
        logic step;    // descend into an existing child
        logic alloc;   // write a cleared node at the next free index
        logic link;    // hook the new node into its parent and descend
        logic mark;    // mark the current node with the route port
        logic note;    // remember the current node if it is marked
        logic full;    // flag an exhausted node pool
        logic finish;  // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic insert;
        logic at_end;
        logic child_hit;
        logic pool_full;
        logic out_ready;
    } t_stat;

endpackage

`default_nettype wire

// ----- src/binary_trie_prefix_lookup_core.sv -----
// ----------------------------------------------------------------------------
// Binary trie prefix lookup core
// Unibit trie longest-prefix match with route insertion.
// ----------------------------------------------------------------------------
// One item is worked at a time. An insert (opcode 0) walks the top
// prefix_length address bits from the root, allocating missing nodes from a
// bump counter, and marks the final node with route_port; when the pool is
// exhausted it reports status 1 and marks nothing. A lookup (opcode 1) walks
// up to ADDRESS_BITS levels and returns the port of the deepest marked node,
// or hit 0 and port 65535 on a miss. Every level is a node memory read, then
// evaluation, and a level that allocates a node adds a link step, because the
// single write port stores the new node and then its parent link. A finished
// item waits while the result register is still full; once that register is
// loaded, the controller returns to idle and accepts the next item.
// The result register lets the next item be accepted while a result waits.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_prefix_lookup_core #(
    parameter int NODE_COUNT   = btrie_pkg::NODE_COUNT_DEF,
    parameter int ADDRESS_BITS = btrie_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_opcode,
    input  wire logic [btrie_pkg::ADDR_IN_W-1:0] i_ip_address,
    input  wire logic [btrie_pkg::PLEN_W-1:0]    i_prefix_length,
    input  wire logic [btrie_pkg::PORT_W-1:0]    i_route_port,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_hit,
    output logic [btrie_pkg::PORT_W-1:0]         o_out_port,
    output logic                                 o_status
);

    btrie_pkg::t_cmd  cmd;
    btrie_pkg::t_stat stat;

    btrie_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    btrie_dpath #(
        .NODE_COUNT   (NODE_COUNT),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_opcode),
        .i_ip_address    (i_ip_address),
        .i_prefix_length (i_prefix_length),
        .i_route_port    (i_route_port),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_out_port      (o_out_port),
        .o_status        (o_status)
    );

endmodule

`default_nettype wire

// ----- src/btrie_ctrl.sv -----
// ----------------------------------------------------------------------------
// Binary trie controller
// Sequences one item at a time through node reads, child allocation, marking
// and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module btrie_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire btrie_pkg::t_stat i_stat,
    output btrie_pkg::t_cmd       o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_LINK = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.note = !i_stat.insert;
                if (i_stat.at_end) begin
                    o_cmd.mark = i_stat.insert;
                    n_state    = S_DONE;
                end else if (i_stat.child_hit) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_READ;
                end else if (!i_stat.insert) begin
                    n_state = S_DONE;
                end else if (i_stat.pool_full) begin
                    o_cmd.full = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.alloc = 1'b1;
                    n_state     = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_READ;
            end
            S_DONE: begin
                if (i_stat.out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- src/btrie_dpath.sv -----
// ----------------------------------------------------------------------------
// Binary trie datapath
// Node memory, walk registers, node allocator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_trie_prefix_lookup_core_defines.svh"

module btrie_dpath #(
    parameter int NODE_COUNT   = btrie_pkg::NODE_COUNT_DEF,
    parameter int ADDRESS_BITS = btrie_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire btrie_pkg::t_cmd                i_cmd,
    output btrie_pkg::t_stat                    o_stat,
    input  wire logic                           i_opcode,
    input  wire logic [btrie_pkg::ADDR_IN_W-1:0] i_ip_address,
    input  wire logic [btrie_pkg::PLEN_W-1:0]   i_prefix_length,
    input  wire logic [btrie_pkg::PORT_W-1:0]   i_route_port,
    input  wire logic                           i_stall,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic [btrie_pkg::PORT_W-1:0]        o_out_port,
    output logic                                o_status
);

    localparam int IW     = $clog2(NODE_COUNT);
    localparam int CW     = $clog2(NODE_COUNT + 1);
    localparam int LW     = $clog2(ADDRESS_BITS + 1);
    localparam int PW     = btrie_pkg::PORT_W;
    localparam int EW     = 2 * IW + PW + 1;
    localparam int MARK_B = PW;
    localparam int C0_LO  = PW + 1;
    localparam int C1_LO  = PW + 1 + IW;

    // Node layout: {child one, child zero, mark, port}.
    logic [EW-1:0] r_mem [NODE_COUNT];
    logic [EW-1:0] r_q;
    logic          r_q_zero;
    logic          r_root_ok;

    logic                    r_op;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [LW-1:0]           r_level;
    logic [LW-1:0]           r_limit;
    logic [IW-1:0]           r_cur;
    logic [CW-1:0]           r_used;
    logic [PW-1:0]           r_port;
    logic                    r_found;
    logic [PW-1:0]           r_best;
    logic                    r_full;

    logic          r_out_valid;
    logic          r_hit;
    logic [PW-1:0] r_oport;
    logic          r_ostatus;

    logic [EW-1:0] node;
    logic [EW-1:0] link_node;
    logic [EW-1:0] mark_node;
    logic [IW-1:0] child;
    logic [IW-1:0] new_idx;
    logic          addr_bit;
    logic          out_ready;
    logic          w_en;
    logic [IW-1:0] w_addr;
    logic [EW-1:0] w_data;
    logic [63:0]   addr_ext;
    logic [6:0]    plen_ext;
    logic [LW-1:0] plen_sat;

    // The root is cleared by reset without touching the memory; until its
    // first write it reads as an empty node.
    assign node     = r_q_zero ? '0 : r_q;
    assign addr_bit = r_addr[ADDRESS_BITS-1];
    assign child    = addr_bit ? node[C1_LO +: IW] : node[C0_LO +: IW];
    assign new_idx  = r_used[IW-1:0];

    always_comb begin
        link_node = node;
        if (addr_bit) begin
            link_node[C1_LO +: IW] = new_idx;
        end else begin
            link_node[C0_LO +: IW] = new_idx;
        end
        mark_node              = node;
        mark_node[MARK_B]      = 1'b1;
        mark_node[PW-1:0]      = r_port;
    end

    assign w_en   = i_cmd.alloc | i_cmd.link | i_cmd.mark;
    assign w_addr = i_cmd.alloc ? new_idx : r_cur;
    assign w_data = i_cmd.alloc ? '0 : (i_cmd.link ? link_node : mark_node);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_q      <= r_mem[r_cur];
            r_q_zero <= (r_cur == '0) && !r_root_ok;
        end
    end

    // Prefix lengths beyond the address width saturate.
    assign addr_ext = {32'b0, i_ip_address};
    assign plen_ext = {1'b0, i_prefix_length};
    assign plen_sat = (plen_ext > 7'(ADDRESS_BITS)) ? LW'(ADDRESS_BITS) : LW'(plen_ext);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_addr  <= addr_ext[ADDRESS_BITS-1:0];
            r_level <= '0;
            r_limit <= (i_opcode == btrie_pkg::OP_INSERT) ? plen_sat : LW'(ADDRESS_BITS);
            r_cur   <= '0;
            r_port  <= i_route_port;
            r_found <= 1'b0;
            r_best  <= btrie_pkg::MISS_PORT;
            r_full  <= 1'b0;
        end else begin
            if (i_cmd.step) begin
                r_cur <= child;
            end else if (i_cmd.link) begin
                r_cur <= new_idx;
            end
            if (i_cmd.step || i_cmd.link) begin
                r_level <= r_level + LW'(1);
                r_addr  <= {r_addr[ADDRESS_BITS-2:0], 1'b0};
            end
            if (i_cmd.note && node[MARK_B]) begin
                r_found <= 1'b1;
                r_best  <= node[PW-1:0];
            end
            if (i_cmd.full) begin
                r_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= CW'(1);
            r_root_ok <= 1'b0;
        end else begin
            if (i_cmd.link) begin
                r_used <= r_used + CW'(1);
            end
            if (w_en && (w_addr == '0)) begin
                r_root_ok <= 1'b1;
            end
        end
    end

    // Result register: the next item may start while a result waits here.
    assign out_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_hit     <= (r_op == btrie_pkg::OP_LOOKUP) && r_found;
            r_oport   <= ((r_op == btrie_pkg::OP_LOOKUP) && r_found) ? r_best
                                                                      : btrie_pkg::MISS_PORT;
            r_ostatus <= r_full;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_hit      = r_hit;
    assign o_out_port = r_oport;
    assign o_status   = r_ostatus;

    assign o_stat.insert    = (r_op == btrie_pkg::OP_INSERT);
    assign o_stat.at_end    = (r_level == r_limit);
    assign o_stat.child_hit = (child != '0);
    assign o_stat.pool_full = (r_used == CW'(NODE_COUNT));
    assign o_stat.out_ready = out_ready;

    `BTRIE_ASSERT_RST(a_used_range, (r_used != '0) && (r_used <= CW'(NODE_COUNT)), "node count out of range")
    `BTRIE_ASSERT_RST(a_alloc_room, i_cmd.alloc |-> !o_stat.pool_full, "allocation from a full pool")
    `BTRIE_ASSERT_RST(a_link_after_alloc, i_cmd.link |-> $past(i_cmd.alloc), "link without allocation")
    `BTRIE_ASSERT_RST(a_finish_room, i_cmd.finish |-> out_ready, "result register overwritten")

endmodule

`default_nettype wire

// ----- bench/binary_trie_prefix_lookup_core_tb.sv -----
// ----------------------------------------------------------------------------
// Binary trie prefix lookup core testbench
// Drives inserts and lookups through the valid/stall input channel. A
// software trie kept beside the block predicts every result, and results are
// checked in order. Directed cases cover empty lookups, the default route,
// full-length and over-long prefixes, nested prefixes and overwrites. Random
// parts cover clustered routes, a long receiver hold and pool exhaustion.
// ----------------------------------------------------------------------------
module binary_trie_prefix_lookup_core_tb;

    localparam int CLK_PERIOD = 12;
    localparam int NODES      = btrie_pkg::NODE_COUNT_DEF;
    localparam int ABITS      = btrie_pkg::ADDRESS_BITS_DEF;
    localparam int LONG_HOLD  = 400;
    localparam int DRAIN_WAIT = 150;

    typedef struct packed {
        logic                          hit;
        logic [btrie_pkg::PORT_W-1:0]  port;
        logic                          status;
    } route_result_t;

    typedef struct {
        logic [31:0] addr;
        int unsigned len;
    } route_entry_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic                           i_opcode;
    logic [btrie_pkg::ADDR_IN_W-1:0] i_ip_address;
    logic [btrie_pkg::PLEN_W-1:0]   i_prefix_length;
    logic [btrie_pkg::PORT_W-1:0]   i_route_port;
    logic                           o_valid;
    logic                           i_stall;
    logic                           o_hit;
    logic [btrie_pkg::PORT_W-1:0]   o_out_port;
    logic                           o_status;

    // Trie shadow used for prediction.
    int unsigned                    kid_zero [NODES];
    int unsigned                    kid_one [NODES];
    logic                           node_marked [NODES];
    logic [btrie_pkg::PORT_W-1:0]   node_port [NODES];
    int unsigned                    nodes_used;
    int unsigned                    pool_full_count;

    route_result_t                  pending_results [$];
    route_entry_t                   known_routes [$];
    logic [31:0]                    cluster_base [8];

    int                             err_count;
    int                             burst_left;
    bit                             sender_eager;
    bit                             hold_request;
    int                             hold_left;
    int                             mode_left;
    int                             phase;
    stall_mode_t                    stall_mode;

    binary_trie_prefix_lookup_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_ip_address    (i_ip_address),
        .i_prefix_length (i_prefix_length),
        .i_route_port    (i_route_port),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_out_port      (o_out_port),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * 600000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [31:0] prefix_mask(int unsigned len);
        logic [63:0] m;
        m = ~((64'd1 << (32 - len)) - 64'd1);
        return m[31:0];
    endfunction

    function automatic logic [31:0] clustered_address();
        logic [63:0] m;
        int unsigned k;
        k = $urandom_range(0, 32);
        m = (64'd1 << k) - 64'd1;
        return cluster_base[$urandom_range(0, 7)] ^ ($urandom & m[31:0]);
    endfunction

    // An address that falls under a route inserted earlier.
    function automatic logic [31:0] covered_address();
        route_entry_t r;
        r = known_routes[$urandom_range(0, known_routes.size() - 1)];
        return (r.addr & prefix_mask(r.len)) | ($urandom & ~prefix_mask(r.len));
    endfunction

    function automatic route_result_t predict_route(logic op, logic [31:0] addr,
            logic [5:0] plen, logic [15:0] port);
        route_result_t res;
        route_entry_t  entry;
        int unsigned   cur;
        int unsigned   nxt;
        int unsigned   depth;
        int unsigned   lvl;
        logic          bitv;
        logic          done;
        logic [15:0]   best;
        res.hit    = 1'b0;
        res.port   = btrie_pkg::MISS_PORT;
        res.status = 1'b0;
        cur        = 0;
        done       = 1'b0;
        if (op == btrie_pkg::OP_INSERT) begin
            depth = (plen > ABITS) ? ABITS : plen;
            for (lvl = 0; lvl < depth && !res.status; lvl++) begin
                bitv = addr[ABITS - 1 - lvl];
                nxt  = bitv ? kid_one[cur] : kid_zero[cur];
                if (nxt == 0) begin
                    if (nodes_used >= NODES) begin
                        res.status = 1'b1;
                    end else begin
                        kid_zero[nodes_used]    = 0;
                        kid_one[nodes_used]     = 0;
                        node_marked[nodes_used] = 1'b0;
                        node_port[nodes_used]   = '0;
                        if (bitv) kid_one[cur] = nodes_used;
                        else      kid_zero[cur] = nodes_used;
                        nxt = nodes_used;
                        nodes_used++;
                    end
                end
                if (!res.status) cur = nxt;
            end
            if (!res.status) begin
                node_marked[cur] = 1'b1;
                node_port[cur]   = port;
                entry.addr = addr;
                entry.len  = depth;
                known_routes.push_back(entry);
            end else begin
                pool_full_count++;
            end
        end else begin
            res.hit = node_marked[0];
            best    = node_port[0];
            for (lvl = 0; lvl < ABITS && !done; lvl++) begin
                nxt = addr[ABITS - 1 - lvl] ? kid_one[cur] : kid_zero[cur];
                if (nxt == 0) begin
                    done = 1'b1;
                end else begin
                    cur = nxt;
                    if (node_marked[cur]) begin
                        res.hit = 1'b1;
                        best    = node_port[cur];
                    end
                end
            end
            res.port = res.hit ? best : btrie_pkg::MISS_PORT;
        end
        return res;
    endfunction

    // Offers one item and waits for the block to take it. Gaps between bursts
    // lower valid first; back-to-back items keep it high.
    task automatic send_item(logic op, logic [31:0] addr, logic [5:0] plen,
            logic [15:0] port);
        int gap;
        if (!sender_eager && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_ip_address    <= addr;
        i_prefix_length <= plen;
        i_route_port    <= port;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_route(op, addr, plen, port));
    endtask

    task automatic send_lookup(logic [31:0] addr);
        send_item(btrie_pkg::OP_LOOKUP, addr, 6'($urandom), 16'($urandom));
    endtask

    task automatic test_empty_lookups();
        send_item(btrie_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
        send_item(btrie_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    endtask

    task automatic test_default_route();
        send_item(btrie_pkg::OP_INSERT, $urandom, 6'd0, 16'h1234);
        send_lookup($urandom);
        send_lookup($urandom);
    endtask

    task automatic test_full_length_routes();
        send_item(btrie_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 16'hFFFF);
        send_item(btrie_pkg::OP_INSERT, 32'h0000_0000, 6'd32, 16'h0000);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'hFFFF_FFFE);
        send_lookup(32'h0000_0000);
        send_lookup(32'h0000_0001);
    endtask

    // Prefix lengths above the address width behave as full-length routes.
    task automatic test_overlong_prefix();
        send_item(btrie_pkg::OP_INSERT, 32'hA5A5_A5A5, 6'd63, 16'hBEEF);
        send_item(btrie_pkg::OP_INSERT, 32'h5A5A_5A5A, 6'd33, 16'h0101);
        send_lookup(32'hA5A5_A5A5);
        send_lookup(32'h5A5A_5A5A);
        send_lookup(32'hA5A5_A5A4);
    endtask

    task automatic test_nested_and_overwrite();
        send_item(btrie_pkg::OP_INSERT, 32'h0A00_0000, 6'd8, 16'h0001);
        send_item(btrie_pkg::OP_INSERT, 32'h0A01_0000, 6'd16, 16'h0002);
        send_lookup(32'h0A01_0203);
        send_lookup(32'h0A02_0304);
        send_item(btrie_pkg::OP_INSERT, 32'h0A01_5555, 6'd16, 16'h0003);
        send_lookup(32'h0A01_FFFF);
    endtask

    task automatic test_clustered_mix(int count);
        int r;
        logic [5:0] plen;
        foreach (cluster_base[i]) cluster_base[i] = $urandom;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_item(logic'($urandom_range(0, 1)), $urandom, 6'($urandom),
                          16'($urandom));
            end else if (r < 50) begin
                plen = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(8, 32));
                send_item(btrie_pkg::OP_INSERT, clustered_address(), plen,
                          16'($urandom));
            end else if ($urandom_range(0, 9) < 7) begin
                send_lookup(covered_address());
            end else begin
                send_lookup(clustered_address());
            end
        end
    endtask

    // The receiver holds off while items keep coming, so the block backs up.
    task automatic test_backpressure(int count);
        sender_eager = 1'b1;
        hold_request = 1'b1;
        repeat (count) begin
            if ($urandom_range(0, 1) == 0)
                send_item(btrie_pkg::OP_INSERT, clustered_address(),
                          6'($urandom_range(4, 24)), 16'($urandom));
            else
                send_lookup(covered_address());
        end
        sender_eager = 1'b0;
    endtask

    task automatic test_pool_exhaustion();
        int sent;
        sent = 0;
        while (pool_full_count < 8 && sent < 600) begin
            send_item(btrie_pkg::OP_INSERT, $urandom, 6'd32, 16'($urandom));
            if (sent % 4 == 0) send_lookup(covered_address());
            sent++;
        end
    endtask

    task automatic test_after_full(int count);
        int r;
        route_entry_t e;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                // Existing paths need no new node, so these still succeed.
                e = known_routes[$urandom_range(0, known_routes.size() - 1)];
                send_item(btrie_pkg::OP_INSERT, e.addr, 6'(e.len), 16'($urandom));
            end else if (r < 60) begin
                send_item(btrie_pkg::OP_INSERT, $urandom, 6'($urandom), 16'($urandom));
            end else if (r < 90) begin
                send_lookup(covered_address());
            end else begin
                send_lookup($urandom);
            end
        end
    endtask

    // Receiver stall pattern, with an occasional long hold on request.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            case (stall_mode)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: i_stall <= ((phase % 5) < 2);
                default:        i_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        route_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result hit=%0b port=%h status=%0b",
                         $time, o_hit, o_out_port, o_status);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit mismatch, expected %0b, actual %0b",
                             $time, want.hit, o_hit);
                    err_count++;
                end
                if (o_out_port !== want.port) begin
                    $display("%0t: out_port mismatch, expected %h, actual %h",
                             $time, want.port, o_out_port);
                    err_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0b, actual %0b",
                             $time, want.status, o_status);
                    err_count++;
                end
            end
        end
    end

    initial begin
        for (int n = 0; n < NODES; n++) begin
            kid_zero[n]    = 0;
            kid_one[n]     = 0;
            node_marked[n] = 1'b0;
            node_port[n]   = '0;
        end
        nodes_used      = 1;
        pool_full_count = 0;
        err_count       = 0;
        burst_left      = 0;
        sender_eager    = 1'b0;
        hold_request    = 1'b0;
        hold_left       = 0;
        mode_left       = 0;
        phase           = 0;
        stall_mode      = STALL_NONE;

        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_stall         <= 1'b0;
        i_opcode        <= btrie_pkg::OP_LOOKUP;
        i_ip_address    <= '0;
        i_prefix_length <= '0;
        i_route_port    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_lookups();
        test_default_route();
        test_full_length_routes();
        test_overlong_prefix();
        test_nested_and_overwrite();
        test_clustered_mix(380);
        test_backpressure(40);
        test_pool_exhaustion();
        test_after_full(160);

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
